// ----- rtl/core/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer to ASCII converter package
// Shared types, character codes and the digit lookup for the converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Conversion modes carried in the input item.
  typedef enum logic [1:0] {
    MODE_SDEC = 2'd0,
    MODE_UDEC = 2'd1,
    MODE_HEXL = 2'd2,
    MODE_HEXU = 2'd3
  } mode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 7;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned DigitIdxW = $clog2(MaxDigits);
  localparam int unsigned CountW    = $clog2(MaxDigits + 1);

  // Reciprocal of ten: q = (v * Recip10) >> RecipShift is exact for 32-bit v.
  localparam logic [ValueW-1:0] Recip10    = 32'hCCCC_CCCD;
  localparam int unsigned       RecipShift = 35;
  localparam int unsigned       ProdW      = 2 * ValueW;

  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharMinus = 7'h2D;
  localparam logic [CharW-1:0] CharLowA  = 7'h61;
  localparam logic [CharW-1:0] CharUpA   = 7'h41;
  localparam logic [DigitW-1:0] DigitTen = 4'd10;

  // Control of the shared divide-by-base unit.
  typedef struct packed {
    logic load;
    logic hex;
  } div_ctl_t;

  // One write into the digit stack.
  typedef struct packed {
    logic                 en;
    logic [DigitIdxW-1:0] idx;
    logic [DigitW-1:0]    digit;
  } push_t;

  // Map a digit value to its ASCII code in the chosen letter case.
  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d,
                                                  input logic upper);
    logic [CharW-1:0] d_ext;
    logic [CharW-1:0] ofs;
    d_ext = {{(CharW - DigitW){1'b0}}, d};
    ofs   = {{(CharW - DigitW){1'b0}}, d - DigitTen};
    if (d < DigitTen) begin
      digit_char = CharZero + d_ext;
    end else if (upper) begin
      digit_char = CharUpA + ofs;
    end else begin
      digit_char = CharLowA + ofs;
    end
  endfunction

endpackage

// ----- rtl/core/itoa_in_if.sv -----
// ----------------------------------------------------------------------------
// Converter input channel
// Valid/ready channel carrying one value and its conversion mode per item.
// ----------------------------------------------------------------------------
interface itoa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  mode;

  modport source (output valid, output value, output mode, input ready);
  modport sink (input valid, input value, input mode, output ready);
endinterface

// ----- rtl/core/itoa_out_if.sv -----
// ----------------------------------------------------------------------------
// Converter output channel
// Valid/ready channel carrying one ASCII character and its last flag per item.
// ----------------------------------------------------------------------------
interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

// ----- rtl/core/itoa_div_unit.sv -----
// ----------------------------------------------------------------------------
// Shared divide-by-base unit
// Registers an operand with its product by the reciprocal of ten and returns
// the quotient and the low digit for base ten or base sixteen.
// ----------------------------------------------------------------------------
module itoa_div_unit (
  input  logic                           clk,
  input  itoa_pkg::div_ctl_t             ctl,
  input  logic [itoa_pkg::ValueW-1:0]    operand,
  output logic [itoa_pkg::ValueW-1:0]    quot,
  output logic [itoa_pkg::DigitW-1:0]    digit
);
  import itoa_pkg::*;

  logic [ValueW-1:0] opnd_r;
  logic [ValueW-1:0] opnd_nxt;
  logic [ProdW-1:0]  prod_r;
  logic [ProdW-1:0]  prod_nxt;
  logic              hex_r;
  logic              hex_nxt;
  logic [ValueW-1:0] dec_q;
  logic [ValueW-1:0] dec_q10;
  logic [ValueW-1:0] dec_rem;

  // Load the operand and its reciprocal product together.
  always_comb begin
    opnd_nxt = opnd_r;
    prod_nxt = prod_r;
    hex_nxt  = hex_r;
    if (ctl.load) begin
      opnd_nxt = operand;
      prod_nxt = operand * Recip10;
      hex_nxt  = ctl.hex;
    end
  end

  always_ff @(posedge clk) begin
    opnd_r <= opnd_nxt;
    prod_r <= prod_nxt;
    hex_r  <= hex_nxt;
  end

  // Decimal quotient from the product; remainder by shift-add back-multiply.
  assign dec_q   = {{RecipShift - ValueW{1'b0}}, prod_r[ProdW-1:RecipShift]};
  assign dec_q10 = {dec_q[ValueW-4:0], 3'b000} + {dec_q[ValueW-2:0], 1'b0};
  assign dec_rem = opnd_r - dec_q10;

  // Hex is a plain shift by one nibble.
  always_comb begin
    if (hex_r) begin
      quot  = {4'b0000, opnd_r[ValueW-1:DigitW]};
      digit = opnd_r[DigitW-1:0];
    end else begin
      quot  = dec_q;
      digit = dec_rem[DigitW-1:0];
    end
  end

endmodule

// ----- rtl/core/itoa_digit_stack.sv -----
// ----------------------------------------------------------------------------
// Digit stack
// Holds the digits of one value, written least significant first and read
// back in reverse order for output.
// ----------------------------------------------------------------------------
module itoa_digit_stack (
  input  logic                              clk,
  input  itoa_pkg::push_t                   push,
  input  logic [itoa_pkg::DigitIdxW-1:0]    rd_idx,
  output logic [itoa_pkg::DigitW-1:0]       rd_digit
);
  import itoa_pkg::*;

  logic [DigitW-1:0] mem_r [MaxDigits];

  // Write one digit per step of the divider.
  always_ff @(posedge clk) begin
    if (push.en) begin
      mem_r[push.idx] <= push.digit;
    end
  end

  assign rd_digit = mem_r[rd_idx];

endmodule

// ----- rtl/core/integer_to_ascii_converter.sv -----
// ----------------------------------------------------------------------------
// Integer to ASCII converter
// Turns a 32-bit value into its decimal or hexadecimal text, one character
// per output item, most significant character first.
// ----------------------------------------------------------------------------
// An item is taken only while the block is idle. After acceptance the
// magnitude is registered and, in the load state, handed to a shared unit
// that multiplies by the reciprocal of ten (or shifts by a nibble for hex);
// each following cycle yields one digit into a small stack.
// The text is then sent one character per cycle while out_ch.ready is high:
// a minus sign first for negative values in signed mode, then the digits.
// The final character of each value has last set.
module integer_to_ascii_converter (
  input  logic        clk,
  input  logic        rst_n,
  itoa_in_if.sink     in_ch,
  itoa_out_if.source  out_ch
);
  import itoa_pkg::*;

  state_t                state_r;
  state_t                state_nxt;
  logic [ValueW-1:0]     mag_r;
  logic [ValueW-1:0]     mag_nxt;
  logic                  neg_r;
  logic                  neg_nxt;
  logic                  hex_r;
  logic                  hex_nxt;
  logic                  upper_r;
  logic                  upper_nxt;
  logic [CountW-1:0]     nd_r;
  logic [CountW-1:0]     nd_nxt;
  logic [DigitIdxW-1:0]  ptr_r;
  logic [DigitIdxW-1:0]  ptr_nxt;

  logic                  in_fire;
  logic                  out_fire;
  logic                  in_neg;
  div_ctl_t              div_ctl;
  logic [ValueW-1:0]     div_operand;
  logic [ValueW-1:0]     quot;
  logic [DigitW-1:0]     digit;
  logic                  quot_zero;
  push_t                 push;
  logic [DigitW-1:0]     rd_digit;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign in_neg    = (in_ch.mode == MODE_SDEC) && in_ch.value[ValueW-1];
  assign quot_zero = (quot == '0);

  // Shared divider and digit store.
  itoa_div_unit u_div (
    .clk     (clk),
    .ctl     (div_ctl),
    .operand (div_operand),
    .quot    (quot),
    .digit   (digit)
  );

  itoa_digit_stack u_stack (
    .clk      (clk),
    .push     (push),
    .rd_idx   (ptr_r),
    .rd_digit (rd_digit)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (quot_zero) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_fire) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire && (ptr_r == '0)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ch.ready      = 1'b0;
    out_ch.valid     = 1'b0;
    out_ch.character = CharMinus;
    out_ch.last      = 1'b0;
    div_ctl.load     = 1'b0;
    div_ctl.hex      = hex_r;
    div_operand      = quot;
    push.en          = 1'b0;
    push.idx         = nd_r[DigitIdxW-1:0];
    push.digit       = digit;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_LOAD: begin
        div_ctl.load = 1'b1;
        div_operand  = mag_r;
      end
      ST_STEP: begin
        push.en      = 1'b1;
        div_ctl.load = !quot_zero;
      end
      ST_SIGN: begin
        out_ch.valid = 1'b1;
      end
      ST_EMIT: begin
        out_ch.valid     = 1'b1;
        out_ch.character = digit_char(rd_digit, upper_r);
        out_ch.last      = (ptr_r == '0);
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // Datapath and counters.
  always_comb begin
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    hex_nxt   = hex_r;
    upper_nxt = upper_r;
    nd_nxt    = nd_r;
    ptr_nxt   = ptr_r;
    if (in_fire) begin
      mag_nxt   = in_neg ? (32'd0 - in_ch.value) : in_ch.value;
      neg_nxt   = in_neg;
      hex_nxt   = in_ch.mode[1];
      upper_nxt = (in_ch.mode == MODE_HEXU);
      nd_nxt    = '0;
    end
    if (state_r == ST_STEP) begin
      nd_nxt = nd_r + 1'b1;
      if (quot_zero) begin
        ptr_nxt = nd_r[DigitIdxW-1:0];
      end
    end
    if ((state_r == ST_EMIT) && out_fire && (ptr_r != '0)) begin
      ptr_nxt = ptr_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      nd_r    <= '0;
      ptr_r   <= '0;
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nd_r    <= nd_nxt;
      ptr_r   <= ptr_nxt;
      neg_r   <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    hex_r   <= hex_nxt;
    upper_r <= upper_nxt;
  end

  // The block never offers a character while it can take a new value.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a character is offered");

  // An accepted value always starts the divider on the next cycle.
  a_load_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_LOAD))
    else $error("divider not loaded after an accepted value");

  // The final character of a value is a digit, never the sign.
  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |-> (out_ch.character != CharMinus))
    else $error("last flag on a minus sign");

  // The digit count never runs past the stack depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (nd_r < CountW'(MaxDigits)))
    else $error("digit stack overflow");

endmodule

// ----- bench/integer_to_ascii_converter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII converter testbench
// Feeds values in all four modes through the input channel and checks every
// character and last flag that comes out against a predicted text, with
// random gaps on the sender side and random stalls on the receiver side.
// ----------------------------------------------------------------------------
module integer_to_ascii_converter_test;
  import itoa_pkg::*;

  // ASCII codes used to build the expected text.
  localparam logic [6:0] AsciiZero  = 7'h30;
  localparam logic [6:0] AsciiMinus = 7'h2D;
  localparam logic [6:0] AsciiLowA  = 7'h61;
  localparam logic [6:0] AsciiUpA   = 7'h41;

  localparam int unsigned RandomValues = 445;
  localparam int unsigned SettleCycles = 30;

  // One value waiting to be sent, with the idle gap that goes before it.
  typedef struct {
    logic [31:0] value;
    mode_t       mode;
    int unsigned gap;
    logic        drain_first;
  } conversion_t;

  // One expected character of the output text.
  typedef struct {
    logic [6:0] code;
    logic       last;
  } text_char_t;

  logic clk;
  logic rst_n;

  itoa_in_if  in_ch ();
  itoa_out_if out_ch ();

  conversion_t pending_values[$];
  text_char_t  text_due[$];
  int unsigned mismatch_count;
  int unsigned send_gap_left;
  int unsigned stall_left;
  int unsigned steady_left;

  integer_to_ascii_converter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Append the text of one value to the queue of expected characters.
  function automatic void predict_text(input logic [31:0] value, input mode_t mode);
    logic [31:0] magnitude;
    logic [3:0]  digit;
    logic        is_hex;
    text_char_t  entry;
    text_char_t  digits[$];
    is_hex    = (mode == MODE_HEXL) || (mode == MODE_HEXU);
    magnitude = value;
    entry.last = 1'b0;
    if (mode == MODE_SDEC && value[31]) begin
      magnitude  = -value;
      entry.code = AsciiMinus;
      text_due.push_back(entry);
    end
    // Digits come out least significant first, so build the text backwards.
    do begin
      if (is_hex) begin
        digit     = magnitude[3:0];
        magnitude = magnitude >> 4;
      end else begin
        digit     = 4'(magnitude % 10);
        magnitude = magnitude / 10;
      end
      if (digit < 4'd10) begin
        entry.code = AsciiZero + 7'(digit);
      end else if (mode == MODE_HEXU) begin
        entry.code = AsciiUpA + 7'(digit - 4'd10);
      end else begin
        entry.code = AsciiLowA + 7'(digit - 4'd10);
      end
      digits.push_front(entry);
    end while (magnitude != 0);
    digits[digits.size() - 1].last = 1'b1;
    foreach (digits[i]) begin
      text_due.push_back(digits[i]);
    end
  endfunction

  // Random value biased toward the interesting corners of each mode.
  function automatic logic [31:0] random_value();
    logic [31:0] power;
    int unsigned exponent;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 20);
      2: return $urandom >> $urandom_range(0, 31);
      3: begin
        // Around a power of ten, where the digit count changes.
        exponent = $urandom_range(0, 9);
        power    = 32'd1;
        repeat (exponent) power = power * 10;
        return power + $urandom_range(0, 2) - 1;
      end
      4: begin
        // Around the signed and unsigned extremes.
        case ($urandom_range(0, 2))
          0: power = 32'h8000_0000;
          1: power = 32'h7FFF_FFFF;
          default: power = 32'hFFFF_FFFF;
        endcase
        return power + $urandom_range(0, 4) - 2;
      end
      default: return $urandom | 32'h8000_0000;
    endcase
  endfunction

  // Stimulus: directed corners first, then random values with random gaps.
  initial begin : stimulus
    conversion_t item;
    logic [31:0] corner_values[$];
    int unsigned steady_items;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.value      = '0;
    in_ch.mode       = MODE_SDEC;
    out_ch.ready     = 1'b0;
    mismatch_count   = 0;
    send_gap_left    = 0;
    stall_left       = 0;
    steady_left      = 0;
    steady_items     = 0;
    item.drain_first = 1'b0;

    // Zero, the most negative value, all ones and the largest positive
    // value, each in every mode.
    corner_values = '{32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
    foreach (corner_values[i]) begin
      for (int m = 0; m < 4; m++) begin
        item.value = corner_values[i];
        item.mode  = mode_t'(m);
        item.gap   = $urandom_range(0, 2);
        pending_values.push_back(item);
      end
    end
    // Digit-count edges and the hex letters in both cases.
    corner_values = '{32'd9, 32'd10, 32'd999_999_999, 32'd1_000_000_000,
                      32'hDEAD_BEEF, 32'h0000_000F, 32'h0000_0010};
    foreach (corner_values[i]) begin
      item.value = corner_values[i];
      item.mode  = (i < 4) ? MODE_UDEC : mode_t'(2 + (i % 2));
      item.gap   = 0;
      pending_values.push_back(item);
    end

    // Random part; the first value waits until the corner texts are all out.
    for (int n = 0; n < RandomValues; n++) begin
      item.value       = random_value();
      item.mode        = mode_t'($urandom_range(0, 3));
      item.drain_first = (n == 0) || ($urandom_range(0, 39) == 0);
      if (steady_items > 0) begin
        steady_items--;
        item.gap = 0;
      end else begin
        item.gap = pick_gap();
        if ($urandom_range(0, 29) == 0) begin
          steady_items = $urandom_range(10, 40);
        end
      end
      pending_values.push_back(item);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until everything sent has come back, then let the block settle.
    while (pending_values.size() != 0 || in_ch.valid || text_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Driver: offers the next pending value once its gap has run out.
  always @(posedge clk) begin : driver
    conversion_t next_item;
    logic        offering;
    offering = in_ch.valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_text(in_ch.value, mode_t'(in_ch.mode));
        offering      = 1'b0;
        send_gap_left = (pending_values.size() != 0) ? pending_values[0].gap : 0;
      end
      if (!offering) begin
        if (send_gap_left > 0) begin
          send_gap_left--;
        end else if (pending_values.size() != 0 &&
                     !(pending_values[0].drain_first && text_due.size() != 0)) begin
          next_item   = pending_values.pop_front();
          in_ch.value <= next_item.value;
          in_ch.mode  <= next_item.mode;
          offering    = 1'b1;
        end
      end
      in_ch.valid <= offering;
    end
  end

  // Monitor: checks each accepted character and drives random stalls.
  always @(posedge clk) begin : monitor
    text_char_t want;
    logic       ready_next;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (text_due.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                    out_ch.character, out_ch.last));
        end else begin
          want = text_due.pop_front();
          if (out_ch.character !== want.code) begin
            report_mismatch($sformatf("character 0x%02h, predicted 0x%02h",
                                      out_ch.character, want.code));
          end
          if (out_ch.last !== want.last) begin
            report_mismatch($sformatf("last %0b on character 0x%02h, predicted %0b",
                                      out_ch.last, want.code, want.last));
          end
        end
      end
      // Stalls are drawn after each accepted character and now and then
      // while idle, with occasional stretches of steady readiness.
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
        if (out_ch.ready && (out_ch.valid || $urandom_range(0, 7) == 0)) begin
          if (steady_left > 0) begin
            steady_left--;
          end else begin
            stall_left = pick_gap();
            if ($urandom_range(0, 39) == 0) begin
              steady_left = $urandom_range(20, 80);
            end
          end
          if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
          end
        end
      end
      out_ch.ready <= ready_next;
    end
  end

  // Hard limit on the run time.
  initial begin : watchdog
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
